FILE: hw/rtl/i2c_seq_pkg.sv
// Package for the I2C master bit sequencer.
// Holds the request and result payload types, command codes, the timeout reset value and a register index.
// No dependencies.
package i2c_seq_pkg;

  // Command codes carried in the action field of a request.
  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_START    = 3'd1;
  localparam logic [2:0] ACT_STOP     = 3'd2;
  localparam logic [2:0] ACT_SEND     = 3'd3;
  localparam logic [2:0] ACT_RECV     = 3'd4;
  localparam logic [2:0] ACT_ACK      = 3'd5;
  localparam logic [2:0] ACT_NACK     = 3'd6;
  localparam logic [2:0] ACT_WAIT_ACK = 3'd7;

  // Reset value of the ACK timeout register.
  localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd50;

  // Register index of the ACK timeout register.
  localparam logic REG_ACK_TIMEOUT = 1'b0;

  // One tick request.
  typedef struct packed {
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       sda_in;
  } req_t;

  // Line levels and status for one tick.
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_fail;
  } res_t;

endpackage

FILE: hw/rtl/i2c_master_bit_sequencer.sv
// I2C master bit sequencer: top level with command sequencing and APB register.
// Depends on i2c_seq_pkg for payload types and command codes.
//
// Each request is one bit-timing tick: it carries the sampled SDA level and, while the block
// is idle, a command (start, stop, send byte, receive byte, ACK, NACK, wait for ACK). Every
// request produces exactly one result holding the SCL and SDA levels to drive during that
// tick, plus busy, done, the last received byte and the ACK failure flag. A request is taken
// on every clock while the result register is empty or being drained, so the block sustains
// one tick per clock; the result appears in the cycle after its request is taken, from the
// single result register. Commands given while busy are ignored. The ack_timeout register (byte
// address 0, reset 50) sets how many high SDA samples a wait for ACK tolerates before it
// issues a stop and raises ack_fail; the sample after that many high ones gives up, so even
// a value of 255 ends after 256 high samples. Write it only while idle.
module i2c_master_bit_sequencer (
  input  logic                clk,
  input  logic                rst,
  // Request channel
  input  logic                req_valid,
  output logic                req_ready,
  input  i2c_seq_pkg::req_t   req,
  // Result channel
  output logic                res_valid,
  input  logic                res_ready,
  output i2c_seq_pkg::res_t   res,
  // Configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // Sequencer state.
  logic [2:0] cmd, cmd_next;
  logic [1:0] phase, phase_next;
  logic [2:0] bit_index, bit_index_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [7:0] timeout_count, timeout_count_next;
  logic       scl_level, scl_level_next;
  logic       sda_level, sda_level_next;
  logic       fail_flag, fail_flag_next;
  logic [7:0] rx_value, rx_value_next;
  logic [7:0] ack_timeout;

  i2c_seq_pkg::res_t res_next;
  logic              req_fire;
  logic              busy, done, tail;
  logic [8:0]        count_inc;

  // A new request is taken whenever the result register is free or drains this cycle.
  assign req_ready = !res_valid || res_ready;
  assign req_fire  = req_valid && req_ready;

  // Configuration register access.
  assign pready = 1'b1;
  assign prdata = {24'd0, ack_timeout};

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout <= i2c_seq_pkg::ACK_TIMEOUT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == i2c_seq_pkg::REG_ACK_TIMEOUT) begin
      ack_timeout <= pwdata[7:0];
    end
  end

  // Next state and tick result for the request at the input.
  always_comb begin
    cmd_next           = cmd;
    phase_next         = phase;
    bit_index_next     = bit_index;
    shift_reg_next     = shift_reg;
    timeout_count_next = timeout_count;
    scl_level_next     = scl_level;
    sda_level_next     = sda_level;
    fail_flag_next     = fail_flag;
    rx_value_next      = rx_value;
    busy               = 1'b0;
    done               = 1'b0;
    tail               = 1'b0;
    count_inc          = {1'b0, timeout_count} + 9'd1;

    // An idle sequencer picks up a new command and runs its first tick at once.
    if (cmd == i2c_seq_pkg::ACT_NONE && req.action != i2c_seq_pkg::ACT_NONE) begin
      cmd_next           = req.action;
      phase_next         = 2'd0;
      bit_index_next     = 3'd0;
      shift_reg_next     = (req.action == i2c_seq_pkg::ACT_SEND) ? req.tx_byte : 8'd0;
      timeout_count_next = 8'd0;
      count_inc          = 9'd1;
      if (req.action == i2c_seq_pkg::ACT_WAIT_ACK) begin
        fail_flag_next = 1'b0;
      end
    end

    if (cmd_next != i2c_seq_pkg::ACT_NONE) begin
      busy = 1'b1;
      case (cmd_next)
        i2c_seq_pkg::ACT_START: begin
          if (phase_next == 2'd0) begin
            sda_level_next = 1'b1;
            scl_level_next = 1'b1;
            phase_next     = 2'd1;
          end else begin
            sda_level_next = 1'b0;
            tail           = 1'b1;
            done           = 1'b1;
          end
        end
        i2c_seq_pkg::ACT_STOP: begin
          if (phase_next == 2'd0) begin
            sda_level_next = 1'b0;
            scl_level_next = 1'b1;
            phase_next     = 2'd1;
          end else begin
            sda_level_next = 1'b1;
            done           = 1'b1;
          end
        end
        i2c_seq_pkg::ACT_SEND: begin
          if (phase_next == 2'd0) begin
            sda_level_next = shift_reg_next[7];
            phase_next     = 2'd1;
          end else if (phase_next == 2'd1) begin
            scl_level_next = 1'b1;
            phase_next     = 2'd2;
          end else begin
            scl_level_next = 1'b0;
            if (bit_index_next == 3'd7) begin
              done = 1'b1;
            end else begin
              bit_index_next = bit_index_next + 3'd1;
              shift_reg_next = {shift_reg_next[6:0], 1'b0};
              phase_next     = 2'd0;
            end
          end
        end
        i2c_seq_pkg::ACT_RECV: begin
          if (phase_next == 2'd0) begin
            // Release SDA before the first bit so the slave can drive it.
            if (bit_index_next == 3'd0) begin
              sda_level_next = 1'b1;
            end
            scl_level_next = 1'b0;
            phase_next     = 2'd1;
          end else begin
            scl_level_next = 1'b1;
            shift_reg_next = {shift_reg_next[6:0], req.sda_in};
            if (bit_index_next == 3'd7) begin
              rx_value_next = shift_reg_next;
              tail          = 1'b1;
              done          = 1'b1;
            end else begin
              bit_index_next = bit_index_next + 3'd1;
              phase_next     = 2'd0;
            end
          end
        end
        i2c_seq_pkg::ACT_ACK, i2c_seq_pkg::ACT_NACK: begin
          if (phase_next == 2'd0) begin
            sda_level_next = (cmd_next == i2c_seq_pkg::ACT_NACK);
            phase_next     = 2'd1;
          end else begin
            scl_level_next = 1'b1;
            tail           = 1'b1;
            done           = 1'b1;
          end
        end
        default: begin
          // Wait for ACK: release SDA, raise SCL, then sample until low or timeout.
          if (phase_next == 2'd0) begin
            sda_level_next = 1'b1;
            phase_next     = 2'd1;
          end else if (phase_next == 2'd1) begin
            scl_level_next = 1'b1;
            phase_next     = 2'd2;
          end else if (phase_next == 2'd2) begin
            if (!req.sda_in) begin
              scl_level_next = 1'b0;
              done           = 1'b1;
            end else if (count_inc > {1'b0, ack_timeout}) begin
              // Timed out: this tick becomes the first half of a stop.
              sda_level_next = 1'b0;
              scl_level_next = 1'b1;
              phase_next     = 2'd3;
            end else begin
              timeout_count_next = count_inc[7:0];
            end
          end else begin
            sda_level_next = 1'b1;
            fail_flag_next = 1'b1;
            done           = 1'b1;
          end
        end
      endcase
    end

    // The tick shows the levels before any trailing SCL low.
    res_next.scl_out  = scl_level_next;
    res_next.sda_out  = sda_level_next;
    res_next.busy_res = busy;
    res_next.done_res = done;
    res_next.rx_byte  = rx_value_next;
    res_next.ack_fail = fail_flag_next;

    if (tail) begin
      scl_level_next = 1'b0;
    end
    if (done) begin
      cmd_next       = i2c_seq_pkg::ACT_NONE;
      phase_next     = 2'd0;
      bit_index_next = 3'd0;
    end
  end

  // State update on each accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd           <= i2c_seq_pkg::ACT_NONE;
      phase         <= 2'd0;
      bit_index     <= 3'd0;
      shift_reg     <= 8'd0;
      timeout_count <= 8'd0;
      scl_level     <= 1'b1;
      sda_level     <= 1'b1;
      fail_flag     <= 1'b0;
      rx_value      <= 8'd0;
    end else if (req_fire) begin
      cmd           <= cmd_next;
      phase         <= phase_next;
      bit_index     <= bit_index_next;
      shift_reg     <= shift_reg_next;
      timeout_count <= timeout_count_next;
      scl_level     <= scl_level_next;
      sda_level     <= sda_level_next;
      fail_flag     <= fail_flag_next;
      rx_value      <= rx_value_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (req_fire) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      res <= res_next;
    end
  end

endmodule
